/* src/smt_pkg.sv */
// Shared types and command codes for the sorted multiset table.
package smt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned CmdW   = 2;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  function automatic logic [ValueW-1:0] order_key(input logic [ValueW-1:0] word);
    order_key = {~word[ValueW-1], word[ValueW-2:0]};
  endfunction

endpackage

/* src/smt_ctrl.sv */
// Controller state machine: capture, execute and output handshake for the table.
module smt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              m_ready_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  output smt_pkg::ctrl_cmd_t cmd_o
);
  import smt_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic capture, execute;

  assign s_ready_o = (state_q == StIdle);
  assign capture   = s_valid_i && s_ready_o;
  assign execute   = (state_q == StExec) && (!out_valid_q || m_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (capture) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (execute) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (execute) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_valid_o     = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.execute = execute;

endmodule

/* src/smt_datapath.sv */
// Datapath: row of sorted entry cells with per-cell compare, shift and result register.
module smt_datapath #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smt_pkg::ctrl_cmd_t         cmd_i,
  input  logic [smt_pkg::CmdW-1:0]   command_i,
  input  logic [smt_pkg::ValueW-1:0] value_i,
  input  logic [smt_pkg::IndexW-1:0] index_i,
  output logic [smt_pkg::CountW-1:0] count_o,
  output logic                       found_o,
  output logic                       full_res_o,
  output logic [smt_pkg::ValueW-1:0] read_value_o
);
  import smt_pkg::*;

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WideW = CntW + IndexW;

  logic [ValueW-1:0] entry_q [DEPTH];
  logic [ValueW-1:0] entry_d [DEPTH];
  logic [ValueW-1:0] shr_in  [DEPTH];
  logic [ValueW-1:0] shl_in  [DEPTH];
  logic [DEPTH-1:0]  prev_le;

  logic [CntW-1:0]   count_q, count_d;
  logic [CmdW-1:0]   cmd_q;
  logic [ValueW-1:0] val_q;
  logic [IndexW-1:0] idx_q;
  logic [DEPTH-1:0]  le_q, ge_q, eq_q;
  logic [DEPTH-1:0]  le_d, ge_d, eq_d;

  logic              table_full, any_eq, idx_hit, wr_en;
  logic [WideW-1:0]  idx_wide, cnt_wide;
  logic [CntW+CountW-1:0] cnt_ext;
  logic [ValueW-1:0] rd_data;

  logic [CountW-1:0] count_res_q;
  logic              found_res_q, full_res_q;
  logic [ValueW-1:0] rd_res_q;
  logic              found_res_d, full_res_d;
  logic [ValueW-1:0] rd_res_d;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic in_use;
    assign in_use  = (CntW'(i) < count_q);
    assign le_d[i] = in_use && (order_key(entry_q[i]) <= order_key(value_i));
    assign ge_d[i] = (order_key(entry_q[i]) >= order_key(value_i));
    assign eq_d[i] = in_use && (entry_q[i] == value_i);

    if (i == 0) begin : g_first
      assign shr_in[i]  = val_q;
      assign prev_le[i] = 1'b0;
    end else begin : g_mid
      assign shr_in[i]  = entry_q[i-1];
      assign prev_le[i] = le_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign shl_in[i] = entry_q[i];
    end else begin : g_next
      assign shl_in[i] = entry_q[i+1];
    end

    always_comb begin
      entry_d[i] = entry_q[i];
      case (cmd_q)
        CMD_INSERT: begin
          if (!le_q[i]) begin
            entry_d[i] = prev_le[i] ? val_q : shr_in[i];
          end
        end
        CMD_DELETE: begin
          if (ge_q[i]) begin
            entry_d[i] = shl_in[i];
          end
        end
        default: entry_d[i] = entry_q[i];
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.execute && wr_en) begin
        entry_q[i] <= entry_d[i];
      end
    end
  end

  assign table_full = (count_q == CntW'(DEPTH));
  assign any_eq     = |eq_q;
  assign idx_wide   = {{CntW{1'b0}}, idx_q};
  assign cnt_wide   = {{IndexW{1'b0}}, count_q};
  assign idx_hit    = (idx_wide < cnt_wide);
  assign rd_data    = entry_q[idx_wide[AddrW-1:0]];

  always_comb begin
    wr_en       = 1'b0;
    count_d     = count_q;
    found_res_d = 1'b0;
    full_res_d  = 1'b0;
    rd_res_d    = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (table_full) begin
          full_res_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end
      CMD_DELETE: begin
        if (any_eq) begin
          wr_en       = 1'b1;
          found_res_d = 1'b1;
          count_d     = count_q - CntW'(1);
        end
      end
      CMD_READ: begin
        if (idx_hit) begin
          found_res_d = 1'b1;
          rd_res_d    = rd_data;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  assign cnt_ext = {{CountW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      val_q <= value_i;
      idx_q <= index_i;
      le_q  <= le_d;
      ge_q  <= ge_d;
      eq_q  <= eq_d;
    end
    if (cmd_i.execute) begin
      count_res_q <= cnt_ext[CountW-1:0];
      found_res_q <= found_res_d;
      full_res_q  <= full_res_d;
      rd_res_q    <= rd_res_d;
    end
  end

  assign count_o      = count_res_q;
  assign found_o      = found_res_q;
  assign full_res_o   = full_res_q;
  assign read_value_o = rd_res_q;

endmodule

/* src/sorted_multiset_table.sv */
// Top level of the sorted multiset table: stream ports, controller and cell datapath.
//
// Usage: each transfer on the slave stream is one command (insert, delete or
// read) and yields exactly one transfer on the master stream carrying the
// entry count after the command, a found flag, a full flag and the value read.
// Entries are signed 32-bit values kept in ascending order; duplicates stay.
// Operation: when the command is taken, every cell compares its entry to the
// value in parallel and the compare results are registered; in the execute
// step the cell row shifts and the result register loads, which raises
// m_axis_tvalid.
// Flow: a new command is taken only once the previous one has been through
// the compare-then-shift pass over the cell row, and it can be taken while the
// previous result still waits in the output register.
// Stall: if the receiver holds m_axis_tready low, the pending command waits in
// the execute step until the output register frees; the table is untouched.
// Reset: the entry count clears to zero at once; no clearing pass is needed,
// since entries at or beyond the count are never read.
module sorted_multiset_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], index[37:32], zero fill
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // count[6:0], read_value[38:7], zero fill
  output logic [1:0]  m_axis_tuser   // found[0], full_res[1]
);
  import smt_pkg::*;

  ctrl_cmd_t         cmd;
  logic [CountW-1:0] count;
  logic              found, full_res;
  logic [ValueW-1:0] read_value;

  smt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  smt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .command_i    (s_axis_tuser),
    .value_i      (s_axis_tdata[31:0]),
    .index_i      (s_axis_tdata[37:32]),
    .count_o      (count),
    .found_o      (found),
    .full_res_o   (full_res),
    .read_value_o (read_value)
  );

  assign m_axis_tdata = {1'b0, read_value, count};
  assign m_axis_tuser = {full_res, found};

endmodule

/* src/smt_checker.sv */
// Port-level checker for the sorted multiset table, bound to the top level.
module smt_checker #(
  parameter int unsigned DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second transfer taken while a command is in work");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("found and full flags both set");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[6:0] == 7'(DEPTH)))
    else $error("full flag with count below depth");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[38:7] == 32'd0))
    else $error("read value nonzero without a hit");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind sorted_multiset_table smt_checker #(.DEPTH(DEPTH)) u_smt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
